>>> sv/mwsa_pkg.sv
// mwsa_pkg: shared types and constants of the metric window statistics block
// no dependencies; used by the interfaces, the divider and the top level
`default_nettype none

package mwsa_pkg;

    // value format: signed q.8 fixed point
    localparam int VALUE_W     = 32;
    localparam int HELD_W      = 7;
    localparam int METRIC_W    = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;

    // threshold registers and the one metric that alarms when falling below
    localparam int LIMIT_REGS   = 8;
    localparam int BELOW_METRIC = 4;

    localparam logic [CFG_DATA_W-1:0] LIMITS_RESET [LIMIT_REGS] = '{
        64'd5497558139136000,
        64'd0,
        64'd4503599627632640,
        64'd0,
        64'd54975581409280,
        64'd0,
        64'd16492674417920,
        64'd0
    };

    typedef enum logic [1:0] {
        ALERT_NONE = 2'd0,
        ALERT_WARN = 2'd1,
        ALERT_CRIT = 2'd2
    } alert_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } mwsa_state_t;

    // threshold test; zero or negative limit means disabled
    function automatic logic crosses(
        input logic                      below,
        input logic signed [VALUE_W-1:0] v,
        input logic signed [VALUE_W-1:0] limit
    );
        logic hit;
        hit = 1'b0;
        if (limit > 32'sd0)
        begin
            hit = below ? (v < limit) : (v > limit);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

>>> sv/mwsa_if.sv
// mwsa_if: valid/ready channels of the metric window statistics block
// depends on mwsa_pkg for the payload widths
`default_nettype none

// sample channel
interface mwsa_sample_if;
    import mwsa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [METRIC_W-1:0]       metric_index;
    logic signed [VALUE_W-1:0] sample_value;

    modport source (output valid, output metric_index, output sample_value, input ready);
    modport sink   (input valid, input metric_index, input sample_value, output ready);
endinterface

// result channel
interface mwsa_result_if;
    import mwsa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] window_average;
    logic signed [VALUE_W-1:0] window_min;
    logic signed [VALUE_W-1:0] window_max;
    logic [1:0]                alert_level;
    logic [HELD_W-1:0]         samples_held;

    modport source (output valid, output window_average, output window_min,
                    output window_max, output alert_level, output samples_held,
                    input ready);
    modport sink   (input valid, input window_average, input window_min,
                    input window_max, input alert_level, input samples_held,
                    output ready);
endinterface

// configuration write channel
interface mwsa_cfg_if;
    import mwsa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mwsa_div.sv
// mwsa_div: iterative signed-by-unsigned restoring divider, one quotient bit a cycle
// depends on mwsa_pkg for the result width
`default_nettype none

module mwsa_div
    import mwsa_pkg::*;
#(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]         divisor,
    output logic                              done,
    output logic signed [VALUE_W-1:0]         quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    neg_reg, neg_next;
    logic [DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [DIVISOR_W-1:0]    den_reg, den_next;
    logic [DIVISOR_W:0]      trial;
    logic [DIVISOR_W:0]      diff;
    logic [DIVIDEND_W-1:0]   signed_quo;

    // one restoring step: shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[DIVIDEND_W-1];
            quo_next  = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // restore the sign, truncating toward zero
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[VALUE_W-1:0];
    assign done       = done_reg;

endmodule

`default_nettype wire

>>> sv/metric_window_stats_alarm.sv
// metric_window_stats_alarm: per-metric sample window, min/max, average and alarm
// depends on mwsa_pkg, the channels in mwsa_if and the divider mwsa_div
`default_nettype none

// One sample (metric index plus signed q.8 value) enters on the sample channel
// and, if the index is below METRIC_COUNT, yields one result: the average of the
// stored window (sum over count, truncated toward zero), the running minimum and
// maximum, the alert level and the window fill count. An out-of-range index is
// taken and dropped with no result. The block works on one sample at a time:
// sample.ready is high only while idle, and a sample passes through the drop,
// add, divide and output states to its result, the average coming from the
// shared divider that retires one quotient bit per cycle; after the result
// transfer the block is ready again the next cycle. The sample ring sits in a
// single-port memory, read into a register on the sample transfer, and needs
// no clearing after reset. Threshold registers can be written at any time,
// cfg.ready is always high; indexes of 8 and up are ignored.

module metric_window_stats_alarm
    import mwsa_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int METRIC_COUNT  = 8
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    mwsa_sample_if.sink    sample,
    mwsa_result_if.source  result,
    mwsa_cfg_if.sink       cfg
);

    localparam int SLOT_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int MET_W      = (METRIC_COUNT > 1) ? $clog2(METRIC_COUNT) : 1;
    localparam int CNT_W      = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W      = VALUE_W + $clog2(HISTORY_DEPTH);
    localparam int ADDR_W     = MET_W + SLOT_W;
    localparam int RING_DEPTH = 2 ** ADDR_W;

    // threshold registers
    logic [CFG_DATA_W-1:0] limits_reg [LIMIT_REGS];

    // per-metric state
    logic [SLOT_W-1:0]        slot_reg [METRIC_COUNT];
    logic [CNT_W-1:0]         fill_reg [METRIC_COUNT];
    logic signed [VALUE_W-1:0] min_reg [METRIC_COUNT];
    logic signed [VALUE_W-1:0] max_reg [METRIC_COUNT];
    logic signed [SUM_W-1:0]  sum_reg  [METRIC_COUNT];

    // sample ring
    logic signed [VALUE_W-1:0] ring [RING_DEPTH];

    // sequencer and item registers
    mwsa_state_t               state_reg, state_next;
    logic [MET_W-1:0]          met_reg, met_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] old_reg;
    logic signed [SUM_W-1:0]   work_reg, work_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [VALUE_W-1:0] min_out_reg, min_out_next;
    logic signed [VALUE_W-1:0] max_out_reg, max_out_next;
    alert_t                    level_reg, level_next;
    logic signed [VALUE_W-1:0] avg_reg, avg_next;

    logic                      in_xfer;
    logic                      in_range;
    logic [MET_W-1:0]          met_in;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      full;
    logic signed [SUM_W-1:0]   sum_new;
    logic [SLOT_W:0]           slot_inc;
    logic [SLOT_W-1:0]         slot_new;
    logic signed [VALUE_W-1:0] crit;
    logic signed [VALUE_W-1:0] warn;
    logic                      below;
    logic                      div_start;
    logic                      div_done;
    logic signed [VALUE_W-1:0] div_quo;
    logic [CNT_W+HELD_W-1:0]   held_ext;

    // handshakes
    assign sample.ready = (state_reg == ST_IDLE);
    assign in_xfer      = sample.valid && sample.ready;
    assign in_range     = int'(sample.metric_index) < METRIC_COUNT;
    assign met_in       = sample.metric_index[MET_W-1:0];
    assign cfg.ready    = 1'b1;

    // ring addressing and per-item arithmetic
    assign rd_addr  = {met_in, slot_reg[met_in]};
    assign wr_addr  = {met_reg, slot_reg[met_reg]};
    assign full     = (fill_reg[met_reg] == CNT_W'(HISTORY_DEPTH));
    assign sum_new  = work_reg + SUM_W'(val_reg);
    assign slot_inc = {1'b0, slot_reg[met_reg]} + 1'b1;
    assign slot_new = (slot_inc >= (SLOT_W+1)'(HISTORY_DEPTH)) ? '0 : slot_inc[SLOT_W-1:0];
    assign crit     = limits_reg[met_reg][CFG_DATA_W-1:VALUE_W];
    assign warn     = limits_reg[met_reg][VALUE_W-1:0];
    assign below    = (int'(met_reg) == BELOW_METRIC);
    assign div_start = (state_reg == ST_ADD);

    // sequencer: next state and item datapath
    always_comb
    begin
        state_next   = state_reg;
        met_next     = met_reg;
        val_next     = val_reg;
        work_next    = work_reg;
        cnt_next     = cnt_reg;
        min_out_next = min_out_reg;
        max_out_next = max_out_reg;
        level_next   = level_reg;
        avg_next     = avg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_range)
                begin
                    met_next   = met_in;
                    val_next   = sample.sample_value;
                    state_next = ST_DROP;
                end
            end
            ST_DROP:
            begin
                // remove the oldest sample once the window is full
                if (full)
                begin
                    work_next = sum_reg[met_reg] - SUM_W'(old_reg);
                    cnt_next  = fill_reg[met_reg];
                end
                else
                begin
                    work_next = sum_reg[met_reg];
                    cnt_next  = fill_reg[met_reg] + 1'b1;
                end
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                min_out_next = (val_reg < min_reg[met_reg]) ? val_reg : min_reg[met_reg];
                max_out_next = (val_reg > max_reg[met_reg]) ? val_reg : max_reg[met_reg];
                priority if (crosses(below, val_reg, crit))
                begin
                    level_next = ALERT_CRIT;
                end
                else if (crosses(below, val_reg, warn))
                begin
                    level_next = ALERT_WARN;
                end
                else
                begin
                    level_next = ALERT_NONE;
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        met_reg     <= met_next;
        val_reg     <= val_next;
        work_reg    <= work_next;
        cnt_reg     <= cnt_next;
        min_out_reg <= min_out_next;
        max_out_reg <= max_out_next;
        level_reg   <= level_next;
        avg_reg     <= avg_next;
    end

    // per-metric state update when the new sample is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < METRIC_COUNT; i++)
            begin
                slot_reg[i] <= '0;
                fill_reg[i] <= '0;
                min_reg[i]  <= {1'b0, {(VALUE_W-1){1'b1}}};
                max_reg[i]  <= {1'b1, {(VALUE_W-1){1'b0}}};
                sum_reg[i]  <= '0;
            end
        end
        else if (state_reg == ST_ADD)
        begin
            slot_reg[met_reg] <= slot_new;
            fill_reg[met_reg] <= cnt_reg;
            min_reg[met_reg]  <= min_out_next;
            max_reg[met_reg]  <= max_out_next;
            sum_reg[met_reg]  <= sum_new;
        end
    end

    // sample ring: read the slot about to be overwritten, write the new sample
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            old_reg <= ring[rd_addr];
        end
        if (state_reg == ST_ADD)
        begin
            ring[wr_addr] <= val_reg;
        end
    end

    // threshold register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIMIT_REGS; i++)
            begin
                limits_reg[i] <= LIMITS_RESET[i];
            end
        end
        else if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(LIMIT_REGS)))
        begin
            limits_reg[cfg.index[$clog2(LIMIT_REGS)-1:0]] <= cfg.data;
        end
    end

    // window average: sum over count
    mwsa_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_new),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result channel
    assign held_ext              = (CNT_W+HELD_W)'(cnt_reg);
    assign result.valid          = (state_reg == ST_OUT);
    assign result.window_average = avg_reg;
    assign result.window_min     = min_out_reg;
    assign result.window_max     = max_out_reg;
    assign result.alert_level    = level_reg;
    assign result.samples_held   = held_ext[HELD_W-1:0];

endmodule

`default_nettype wire
